FILE: hdl/kdq_pkg.sv
// ----------------------------------------------------------------------------
// kdq_pkg
// Shared types, operation and status codes for the keyed deque and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package kdq_pkg;

    localparam int DEPTH        = 16;
    localparam int KEY_BITS     = 24;
    localparam int PAYLOAD_BITS = 32;
    localparam int OP_BITS      = 3;
    localparam int STATUS_BITS  = 2;
    localparam int COUNT_BITS   = 5;

    localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_DELETE_KEY = 3'd3;
    localparam logic [OP_BITS-1:0] OP_READ_FRONT = 3'd4;

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [OP_BITS-1:0]      operation;
        logic [KEY_BITS-1:0]     entry_key;
        logic [PAYLOAD_BITS-1:0] entry_payload;
    } request_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]  status;
        logic [KEY_BITS-1:0]     front_key;
        logic [PAYLOAD_BITS-1:0] front_payload;
        logic                    list_empty;
        logic [COUNT_BITS-1:0]   entry_count;
        logic [COUNT_BITS-1:0]   removed_count;
    } result_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD_BACK,
        CELL_SHIFT_RIGHT,
        CELL_SHIFT_LEFT,
        CELL_MARK,
        CELL_COMPACT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } cell_cmd_t;

    typedef struct packed {
        logic                    valid;
        logic                    mark;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } cell_data_t;

endpackage

`default_nettype wire

FILE: hdl/kdq_cell.sv
// ----------------------------------------------------------------------------
// kdq_cell
// One slot of the deque: holds a record, a valid bit and a delete mark, and
// moves its record to or from its neighbors, or loads a new one, as the broadcast command says.
// ----------------------------------------------------------------------------
`default_nettype none

module kdq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kdq_pkg::cell_cmd_t cmd,
    input  wire kdq_pkg::cell_data_t left,
    input  wire kdq_pkg::cell_data_t right,
    input  wire logic               hit_in,
    output logic                    hit_out,
    output kdq_pkg::cell_data_t     data
);

    logic                             valid_reg, valid_next;
    logic                             mark_reg, mark_next;
    logic [kdq_pkg::KEY_BITS-1:0]     key_reg, key_next;
    logic [kdq_pkg::PAYLOAD_BITS-1:0] payload_reg, payload_next;

    always_comb
    begin
        valid_next   = valid_reg;
        mark_next    = mark_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        case (cmd.op)
            kdq_pkg::CELL_LOAD_BACK:
            begin
                if (left.valid && !valid_reg)
                begin
                    valid_next   = 1'b1;
                    mark_next    = 1'b0;
                    key_next     = cmd.key;
                    payload_next = cmd.payload;
                end
            end
            kdq_pkg::CELL_SHIFT_RIGHT:
            begin
                valid_next   = left.valid;
                mark_next    = 1'b0;
                key_next     = left.key;
                payload_next = left.payload;
            end
            kdq_pkg::CELL_SHIFT_LEFT:
            begin
                valid_next   = right.valid;
                mark_next    = 1'b0;
                key_next     = right.key;
                payload_next = right.payload;
            end
            kdq_pkg::CELL_MARK:
            begin
                mark_next = valid_reg && (key_reg == cmd.key);
            end
            kdq_pkg::CELL_COMPACT:
            begin
                if (hit_in || mark_reg)
                begin
                    valid_next   = right.valid;
                    mark_next    = right.mark;
                    key_next     = right.key;
                    payload_next = right.payload;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign hit_out       = hit_in | mark_reg;
    assign data.valid    = valid_reg;
    assign data.mark     = mark_reg;
    assign data.key      = key_reg;
    assign data.payload  = payload_reg;

endmodule

`default_nettype wire

FILE: hdl/keyed_deque_with_delete.sv
// ----------------------------------------------------------------------------
// keyed_deque_with_delete
// Push, pop, read: request accepted, cells updated that cycle; the result is
// registered in the report state once the output is not stalled, and no new
// request is taken until then. Delete by key: the cells mark matching records,
// then the chain squeezes out one marked record per cycle before the report.
// Reset clears the valid bits, the count and the result register; the stored
// records themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_deque_with_delete #(
    parameter int DEPTH = kdq_pkg::DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              request_valid,
    output logic                   request_stall,
    input  wire kdq_pkg::request_t request,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output kdq_pkg::result_t       result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPACT,
        S_REPORT
    } state_t;

    state_t                              state_reg, state_next;
    logic [CNT_W-1:0]                    occ_reg, occ_next;
    logic [CNT_W-1:0]                    removed_reg, removed_next;
    logic [kdq_pkg::STATUS_BITS-1:0]     status_reg, status_next;
    logic                                out_valid_reg, out_valid_next;
    kdq_pkg::result_t                    result_reg, result_next;

    kdq_pkg::cell_cmd_t                  cmd;
    kdq_pkg::cell_data_t                 cell_data [DEPTH];
    logic                                hit [DEPTH+1];
    logic                                accept;
    logic                                full;
    logic                                empty;

    assign request_stall = (state_reg != S_IDLE);
    assign accept        = request_valid && !request_stall;
    assign full          = (occ_reg == CNT_W'(DEPTH));
    assign empty         = (occ_reg == '0);
    assign hit[0]        = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            kdq_pkg::cell_data_t left_in;
            kdq_pkg::cell_data_t right_in;
            if (g == 0)
            begin : g_first
                assign left_in.valid   = 1'b1;
                assign left_in.mark    = 1'b0;
                assign left_in.key     = request.entry_key;
                assign left_in.payload = request.entry_payload;
            end
            else
            begin : g_mid
                assign left_in = cell_data[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_in = '0;
            end
            else
            begin : g_inner
                assign right_in = cell_data[g+1];
            end
            kdq_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .left    (left_in),
                .right   (right_in),
                .hit_in  (hit[g]),
                .hit_out (hit[g+1]),
                .data    (cell_data[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && result_stall;
        result_next    = result_reg;
        cmd.op         = kdq_pkg::CELL_HOLD;
        cmd.key        = request.entry_key;
        cmd.payload    = request.entry_payload;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    removed_next = '0;
                    status_next  = kdq_pkg::STATUS_OK;
                    state_next   = S_REPORT;
                    case (request.operation)
                        kdq_pkg::OP_PUSH_BACK,
                        kdq_pkg::OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = kdq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                cmd.op   = (request.operation == kdq_pkg::OP_PUSH_BACK)
                                           ? kdq_pkg::CELL_LOAD_BACK
                                           : kdq_pkg::CELL_SHIFT_RIGHT;
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        kdq_pkg::OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = kdq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd.op       = kdq_pkg::CELL_SHIFT_LEFT;
                                occ_next     = occ_reg - CNT_W'(1);
                                removed_next = CNT_W'(1);
                            end
                        end
                        kdq_pkg::OP_DELETE_KEY:
                        begin
                            if (empty)
                            begin
                                status_next = kdq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd.op     = kdq_pkg::CELL_MARK;
                                state_next = S_COMPACT;
                            end
                        end
                        default:
                        begin
                            status_next = empty ? kdq_pkg::STATUS_EMPTY : kdq_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            S_COMPACT:
            begin
                if (hit[DEPTH])
                begin
                    cmd.op       = kdq_pkg::CELL_COMPACT;
                    removed_next = removed_reg + CNT_W'(1);
                    occ_next     = occ_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = (removed_reg == '0) ? kdq_pkg::STATUS_NOT_FOUND
                                                      : kdq_pkg::STATUS_OK;
                    state_next  = S_REPORT;
                end
            end
            S_REPORT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next            = 1'b1;
                    result_next.status        = status_reg;
                    result_next.front_key     = cell_data[0].valid ? cell_data[0].key : '0;
                    result_next.front_payload = cell_data[0].valid ? cell_data[0].payload : '0;
                    result_next.list_empty    = empty;
                    result_next.entry_count   = kdq_pkg::COUNT_BITS'(occ_reg);
                    result_next.removed_count = kdq_pkg::COUNT_BITS'(removed_reg);
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            removed_reg   <= '0;
            status_reg    <= kdq_pkg::STATUS_OK;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            removed_reg   <= removed_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
